/* sv/gps_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gps_pkg
// Types, constants and the arithmetic microcode shared by the
// stencil right-hand-side controller and datapath.
// ----------------------------------------------------------------------------
package gps_pkg;

    localparam int DATA_W = 32;
    localparam int DIFF_W = 35;
    localparam int PROD_W = DATA_W + DIFF_W;
    localparam int ACC_W  = 72;
    localparam int TAG_W  = 10;
    localparam int SIZE_W = 11;
    localparam int STEP_W = 4;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LAP_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAP_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_G        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 3'd4;

    localparam logic signed [DATA_W-1:0] LAP_RESET  = 32'sd16777216;
    localparam logic [SIZE_W-1:0]        SIZE_RESET = 11'd1024;
    localparam logic [SIZE_W-1:0]        SIZE_MIN   = 11'd3;
    localparam logic [SIZE_W-1:0]        ROW_LIMIT  = 11'd1024;

    // microcode entry points and last step
    localparam logic [STEP_W-1:0] STEP_INT_FIRST = 4'd0;
    localparam logic [STEP_W-1:0] STEP_BND_FIRST = 4'd5;
    localparam logic [STEP_W-1:0] STEP_LAST      = 4'd12;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_CRE_CRE,
        MUL_CIM_CIM,
        MUL_G_DENS,
        MUL_S_CRE,
        MUL_S_CIM,
        MUL_LX_DXR,
        MUL_LY_DYR,
        MUL_LX_DXI,
        MUL_LY_DYI
    } t_mul_sel;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_DENS_LO,
        ACC_DENS_HI,
        ACC_S,
        ACC_KRE_ADD,
        ACC_KIM_ADD,
        ACC_KRE_SUB,
        ACC_KIM_SUB
    } t_acc_op;

    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_PU,
        CAP_PL,
        CAP_PC,
        CAP_PR
    } t_cap;

    typedef struct packed {
        t_mul_sel mul;
        t_acc_op  acc;
    } t_uop;

    typedef struct packed {
        logic             accept;
        logic             rd_en;
        logic             prd_en;
        t_cap             cap;
        logic             wr_en;
        logic             ld_int;
        logic             ld_bnd;
        t_uop             uop;
        logic             load_out;
        logic [TAG_W-1:0] out_row;
        logic [TAG_W-1:0] out_col;
        logic             out_last;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    // a step issues at most one product; each product is consumed by the step after it
    function automatic t_uop f_uop(input logic [STEP_W-1:0] step);
        t_uop u;
        u = '{mul: MUL_NONE, acc: ACC_NONE};
        case (step)
            4'd0:    u = '{mul: MUL_LX_DXR,  acc: ACC_NONE};
            4'd1:    u = '{mul: MUL_LY_DYR,  acc: ACC_KRE_ADD};
            4'd2:    u = '{mul: MUL_LX_DXI,  acc: ACC_KRE_ADD};
            4'd3:    u = '{mul: MUL_LY_DYI,  acc: ACC_KIM_ADD};
            4'd4:    u = '{mul: MUL_NONE,    acc: ACC_KIM_ADD};
            4'd5:    u = '{mul: MUL_CRE_CRE, acc: ACC_NONE};
            4'd6:    u = '{mul: MUL_CIM_CIM, acc: ACC_DENS_LO};
            4'd7:    u = '{mul: MUL_NONE,    acc: ACC_DENS_HI};
            4'd8:    u = '{mul: MUL_G_DENS,  acc: ACC_NONE};
            4'd9:    u = '{mul: MUL_NONE,    acc: ACC_S};
            4'd10:   u = '{mul: MUL_S_CRE,   acc: ACC_NONE};
            4'd11:   u = '{mul: MUL_S_CIM,   acc: ACC_KRE_SUB};
            4'd12:   u = '{mul: MUL_NONE,    acc: ACC_KIM_SUB};
            default: u = '{mul: MUL_NONE,    acc: ACC_NONE};
        endcase
        return u;
    endfunction

    function automatic logic signed [DATA_W-1:0] f_sat32(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] res;
        if (v[ACC_W-1:DATA_W-1] == '0 || v[ACC_W-1:DATA_W-1] == '1) begin
            res = v[DATA_W-1:0];
        end else if (v[ACC_W-1]) begin
            res = 32'sh8000_0000;
        end else begin
            res = 32'sh7FFF_FFFF;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* sv/gross_pitaevskii_stencil_rhs_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gross_pitaevskii_stencil_rhs_core
// Streaming five-point stencil plus nonlinear term for a complex
// wavefunction grid in raster order, with two-row line stores.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_stall    i_psi_re, i_psi_im, i_potential
//   result    out        o_out_valid / i_out_stall  o_k_re, o_k_im, o_out_row,
//                                                   o_out_col, o_last
//   config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One item at a time; one shared 32x35 multiplier runs the microcode.
// An item yields no result, a boundary result, an interior result or both;
// a result that waits in the result register holds up the next item.
// The interior path adds the states S_RD0 to S_RD4 for the four line-store reads.
// Reset is synchronous; line stores are not cleared.
// A stalled result register holds; the next item is accepted once the
// current item's last result sits in it.
// ----------------------------------------------------------------------------
module gross_pitaevskii_stencil_rhs_core import gps_pkg::*; #(
    parameter int MAX_COLS  = 1024,
    parameter int FRAC_BITS = 24
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic signed [DATA_W-1:0]  i_psi_re,
    input  wire logic signed [DATA_W-1:0]  i_psi_im,
    input  wire logic signed [DATA_W-1:0]  i_potential,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic signed [DATA_W-1:0]       o_k_re,
    output logic signed [DATA_W-1:0]       o_k_im,
    output logic [TAG_W-1:0]               o_out_row,
    output logic [TAG_W-1:0]               o_out_col,
    output logic                           o_last,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [DATA_W-1:0]         i_cfg_data
);

    localparam int COL_LIMIT = (MAX_COLS < 1024) ? MAX_COLS : 1024;
    localparam int CW        = $clog2(COL_LIMIT);

    t_cmd          w_cmd;
    t_sts          w_sts;
    logic [CW:0]   w_rd_addr;
    logic [CW-1:0] w_prd_addr;
    logic [CW:0]   w_wr_addr;
    logic [CW-1:0] w_pwr_addr;

    gps_ctrl #(
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_size (i_cfg_data[SIZE_W-1:0]),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_rd_addr  (w_rd_addr),
        .o_prd_addr (w_prd_addr),
        .o_wr_addr  (w_wr_addr),
        .o_pwr_addr (w_pwr_addr)
    );

    gps_dpath #(
        .MAX_COLS  (MAX_COLS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_rd_addr   (w_rd_addr),
        .i_prd_addr  (w_prd_addr),
        .i_wr_addr   (w_wr_addr),
        .i_pwr_addr  (w_pwr_addr),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_psi_re    (i_psi_re),
        .i_psi_im    (i_psi_im),
        .i_potential (i_potential),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_k_re      (o_k_re),
        .o_k_im      (o_k_im),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire

/* sv/gps_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gps_ctrl
// Sequencer: grid position, line-store addressing, microcode stepping
// and result tagging.
// ----------------------------------------------------------------------------
module gps_ctrl import gps_pkg::*; #(
    parameter int  MAX_COLS  = 1024,
    localparam int COL_LIMIT = (MAX_COLS < 1024) ? MAX_COLS : 1024,
    localparam int CW        = $clog2(COL_LIMIT)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [SIZE_W-1:0]     i_cfg_size,
    input  wire t_sts                  i_sts,
    output t_cmd                       o_cmd,
    output logic [CW:0]                o_rd_addr,
    output logic [CW-1:0]              o_prd_addr,
    output logic [CW:0]                o_wr_addr,
    output logic [CW-1:0]              o_pwr_addr
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_RD2,
        S_RD3,
        S_RD4,
        S_WR,
        S_SET_INT,
        S_SET_BND,
        S_RUN,
        S_LOAD
    } t_state;

    t_state              r_state;
    logic [SIZE_W-1:0]   r_num_rows;
    logic [SIZE_W-1:0]   r_num_cols;
    logic [TAG_W-1:0]    r_row;
    logic [CW-1:0]       r_col;
    logic                r_in_ok;
    logic                r_prev_ok;
    logic [CW-1:0]       r_prev_col;
    logic                r_prev_par;
    logic [TAG_W-1:0]    r_cur_row;
    logic [CW-1:0]       r_cur_col;
    logic                r_do_int;
    logic                r_do_bnd;
    logic                r_last;
    logic                r_phase_int;
    logic [STEP_W-1:0]   r_step;

    logic [SIZE_W-1:0]   w_rows;
    logic [SIZE_W-1:0]   w_cols;
    logic [TAG_W-1:0]    w_row_last;
    logic [CW-1:0]       w_col_last;
    logic                w_accept;
    logic                w_do_int;
    logic                w_do_bnd;
    logic                w_restart;
    logic                w_par;

    always_comb begin
        if (r_num_rows < SIZE_MIN) begin
            w_rows = SIZE_MIN;
        end else if (r_num_rows > ROW_LIMIT) begin
            w_rows = ROW_LIMIT;
        end else begin
            w_rows = r_num_rows;
        end
        if (r_num_cols < SIZE_MIN) begin
            w_cols = SIZE_MIN;
        end else if (r_num_cols > SIZE_W'(COL_LIMIT)) begin
            w_cols = SIZE_W'(COL_LIMIT);
        end else begin
            w_cols = r_num_cols;
        end
    end

    assign w_row_last = TAG_W'(w_rows - 11'd1);
    assign w_col_last = CW'(w_cols - 11'd1);
    assign o_in_stall = (r_state != S_IDLE) | ~i_rst_n;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_do_int   = (r_row >= TAG_W'(2)) && (r_col >= CW'(2)) && r_in_ok;
    assign w_do_bnd   = (r_row == '0) || (r_row == w_row_last)
                     || (r_col == '0) || (r_col == w_col_last);
    assign w_restart  = i_cfg_we && (i_cfg_idx == CFG_NUM_ROWS || i_cfg_idx == CFG_NUM_COLS);
    assign w_par      = r_cur_row[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num_rows  <= SIZE_RESET;
            r_num_cols  <= SIZE_RESET;
            r_row       <= '0;
            r_col       <= '0;
            r_in_ok     <= 1'b0;
            r_prev_ok   <= 1'b0;
            r_prev_col  <= '0;
            r_prev_par  <= 1'b0;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_do_int    <= 1'b0;
            r_do_bnd    <= 1'b0;
            r_last      <= 1'b0;
            r_phase_int <= 1'b0;
            r_step      <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_prev_ok  <= r_in_ok;
                        r_prev_col <= r_cur_col;
                        r_prev_par <= r_cur_row[0];
                        r_cur_row  <= r_row;
                        r_cur_col  <= r_col;
                        r_in_ok    <= 1'b1;
                        r_do_int   <= w_do_int;
                        r_do_bnd   <= w_do_bnd;
                        r_last     <= (r_row == w_row_last) && (r_col == w_col_last);
                        // advance raster position
                        if (r_col == w_col_last) begin
                            r_col <= '0;
                            r_row <= (r_row == w_row_last) ? '0 : r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                        r_state <= w_do_int ? S_RD0 : S_WR;
                    end
                end
                S_RD0: r_state <= S_RD1;
                S_RD1: r_state <= S_RD2;
                S_RD2: r_state <= S_RD3;
                S_RD3: r_state <= S_RD4;
                S_RD4: r_state <= S_SET_INT;
                S_WR:  r_state <= r_do_bnd ? S_SET_BND : S_IDLE;
                S_SET_INT: begin
                    r_step      <= STEP_INT_FIRST;
                    r_phase_int <= 1'b1;
                    r_state     <= S_RUN;
                end
                S_SET_BND: begin
                    r_step      <= STEP_BND_FIRST;
                    r_phase_int <= 1'b0;
                    r_state     <= S_RUN;
                end
                S_RUN: begin
                    if (r_step == STEP_LAST) begin
                        r_state <= S_LOAD;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_LOAD: begin
                    if (i_sts.out_free) begin
                        r_state <= (r_phase_int && r_do_bnd) ? S_SET_BND : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (i_cfg_we && i_cfg_idx == CFG_NUM_ROWS) begin
                r_num_rows <= i_cfg_size;
            end
            if (i_cfg_we && i_cfg_idx == CFG_NUM_COLS) begin
                r_num_cols <= i_cfg_size;
            end
            // size change: start a new grid and drop the held point
            if (w_restart) begin
                r_row   <= '0;
                r_col   <= '0;
                r_in_ok <= 1'b0;
            end
        end
    end

    assign o_wr_addr  = {r_prev_par, r_prev_col};
    assign o_pwr_addr = r_prev_col;

    always_comb begin
        o_cmd      = '0;
        o_cmd.uop  = '{mul: MUL_NONE, acc: ACC_NONE};
        o_cmd.cap  = CAP_NONE;
        o_rd_addr  = '0;
        o_prd_addr = r_cur_col - 1'b1;
        case (r_state)
            S_IDLE: o_cmd.accept = w_accept;
            S_RD0: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.prd_en = 1'b1;
                o_rd_addr    = {w_par, r_cur_col - CW'(1)};
            end
            S_RD1: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.cap   = CAP_PU;
                o_rd_addr   = {~w_par, r_cur_col - CW'(2)};
            end
            S_RD2: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.cap   = CAP_PL;
                o_rd_addr   = {~w_par, r_cur_col - CW'(1)};
            end
            S_RD3: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.cap   = CAP_PC;
                o_rd_addr   = {~w_par, r_cur_col};
            end
            S_RD4: begin
                o_cmd.cap   = CAP_PR;
                o_cmd.wr_en = r_prev_ok;
            end
            S_WR:      o_cmd.wr_en  = r_prev_ok;
            S_SET_INT: o_cmd.ld_int = 1'b1;
            S_SET_BND: o_cmd.ld_bnd = 1'b1;
            S_RUN:     o_cmd.uop    = f_uop(r_step);
            S_LOAD: begin
                o_cmd.load_out = i_sts.out_free;
                if (r_phase_int) begin
                    o_cmd.out_row  = r_cur_row - 1'b1;
                    o_cmd.out_col  = TAG_W'(r_cur_col - CW'(1));
                    o_cmd.out_last = 1'b0;
                end else begin
                    o_cmd.out_row  = r_cur_row;
                    o_cmd.out_col  = TAG_W'(r_cur_col);
                    o_cmd.out_last = r_last;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != S_IDLE)
        else $error("accepted item did not start processing");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> r_step <= STEP_LAST)
        else $error("microcode step out of range");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free)
        else $error("result loaded over an untaken result");

    a_int_needs_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RD4 |-> r_prev_ok && r_do_int)
        else $error("interior read without a held point");

endmodule
`default_nettype wire

/* sv/gps_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gps_dpath
// Line stores, second differences, shared multiplier with accumulators,
// coefficient registers and the result register.
// ----------------------------------------------------------------------------
module gps_dpath import gps_pkg::*; #(
    parameter int  MAX_COLS  = 1024,
    parameter int  FRAC_BITS = 24,
    localparam int COL_LIMIT = (MAX_COLS < 1024) ? MAX_COLS : 1024,
    localparam int CW        = $clog2(COL_LIMIT)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_cmd                        i_cmd,
    output t_sts                             o_sts,
    input  wire logic [CW:0]                 i_rd_addr,
    input  wire logic [CW-1:0]               i_prd_addr,
    input  wire logic [CW:0]                 i_wr_addr,
    input  wire logic [CW-1:0]               i_pwr_addr,
    input  wire logic                        i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [DATA_W-1:0]           i_cfg_data,
    input  wire logic signed [DATA_W-1:0]    i_psi_re,
    input  wire logic signed [DATA_W-1:0]    i_psi_im,
    input  wire logic signed [DATA_W-1:0]    i_potential,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic signed [DATA_W-1:0]         o_k_re,
    output logic signed [DATA_W-1:0]         o_k_im,
    output logic [TAG_W-1:0]                 o_out_row,
    output logic [TAG_W-1:0]                 o_out_col,
    output logic                             o_last
);

    logic [2*DATA_W-1:0] psi_mem [0:(2**(CW+1))-1];
    logic [DATA_W-1:0]   pot_mem [0:(2**CW)-1];

    logic signed [DATA_W-1:0] r_lap_x, r_lap_y, r_g;
    logic [2*DATA_W-1:0]      r_psi_q;
    logic [DATA_W-1:0]        r_pot_q;
    logic [2*DATA_W-1:0]      r_pu, r_pl, r_pc, r_pr;
    logic signed [DATA_W-1:0] r_in_re, r_in_im, r_in_pot;
    logic signed [DATA_W-1:0] r_hold_re, r_hold_im, r_hold_pot;
    logic signed [DATA_W-1:0] r_cre, r_cim, r_cpot;
    logic signed [DIFF_W-1:0] r_dxr, r_dxi, r_dyr, r_dyi;
    logic signed [DATA_W-1:0] r_dens, r_s;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_t, r_kre, r_kim;
    logic                     r_out_valid;

    logic signed [DATA_W-1:0] w_op_a;
    logic signed [DIFF_W-1:0] w_op_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_q;
    logic signed [ACC_W-1:0]  w_qx;
    logic signed [DATA_W-1:0] w_cre, w_cim;

    function automatic logic signed [DIFF_W-1:0] f_diff(
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b,
        input logic [DATA_W-1:0] c
    );
        return DIFF_W'($signed(a)) + DIFF_W'($signed(b))
             - DIFF_W'($signed(c)) - DIFF_W'($signed(c));
    endfunction

    // line stores: hold write comes after this item's reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            psi_mem[i_wr_addr]  <= {r_hold_im, r_hold_re};
            pot_mem[i_pwr_addr] <= r_hold_pot;
        end
        if (i_cmd.rd_en) begin
            r_psi_q <= psi_mem[i_rd_addr];
        end
        if (i_cmd.prd_en) begin
            r_pot_q <= pot_mem[i_prd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lap_x <= LAP_RESET;
            r_lap_y <= LAP_RESET;
            r_g     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LAP_X: r_lap_x <= i_cfg_data;
                CFG_LAP_Y: r_lap_y <= i_cfg_data;
                CFG_G:     r_g     <= i_cfg_data;
                default:   r_g     <= r_g;
            endcase
        end
    end

    always_comb begin
        case (i_cmd.uop.mul)
            MUL_CRE_CRE: begin w_op_a = r_cre;   w_op_b = DIFF_W'(r_cre);  end
            MUL_CIM_CIM: begin w_op_a = r_cim;   w_op_b = DIFF_W'(r_cim);  end
            MUL_G_DENS:  begin w_op_a = r_g;     w_op_b = DIFF_W'(r_dens); end
            MUL_S_CRE:   begin w_op_a = r_s;     w_op_b = DIFF_W'(r_cre);  end
            MUL_S_CIM:   begin w_op_a = r_s;     w_op_b = DIFF_W'(r_cim);  end
            MUL_LX_DXR:  begin w_op_a = r_lap_x; w_op_b = r_dxr;           end
            MUL_LY_DYR:  begin w_op_a = r_lap_y; w_op_b = r_dyr;           end
            MUL_LX_DXI:  begin w_op_a = r_lap_x; w_op_b = r_dxi;           end
            MUL_LY_DYI:  begin w_op_a = r_lap_y; w_op_b = r_dyi;           end
            default:     begin w_op_a = '0;      w_op_b = '0;              end
        endcase
    end

    assign w_prod = w_op_a * w_op_b;
    assign w_q    = r_prod >>> FRAC_BITS;
    assign w_qx   = ACC_W'(w_q);
    assign w_cre  = r_pc[DATA_W-1:0];
    assign w_cim  = r_pc[2*DATA_W-1:DATA_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_hold_re  <= r_in_re;
            r_hold_im  <= r_in_im;
            r_hold_pot <= r_in_pot;
            r_in_re    <= i_psi_re;
            r_in_im    <= i_psi_im;
            r_in_pot   <= i_potential;
        end
        case (i_cmd.cap)
            CAP_PU:  r_pu <= r_psi_q;
            CAP_PL:  r_pl <= r_psi_q;
            CAP_PC:  r_pc <= r_psi_q;
            CAP_PR:  r_pr <= r_psi_q;
            default: r_pr <= r_pr;
        endcase
        if (i_cmd.ld_int) begin
            r_dxr  <= f_diff(r_pu[DATA_W-1:0], r_hold_re, w_cre);
            r_dxi  <= f_diff(r_pu[2*DATA_W-1:DATA_W], r_hold_im, w_cim);
            r_dyr  <= f_diff(r_pl[DATA_W-1:0], r_pr[DATA_W-1:0], w_cre);
            r_dyi  <= f_diff(r_pl[2*DATA_W-1:DATA_W], r_pr[2*DATA_W-1:DATA_W], w_cim);
            r_cre  <= w_cre;
            r_cim  <= w_cim;
            r_cpot <= r_pot_q;
            r_kre  <= '0;
            r_kim  <= '0;
        end
        if (i_cmd.ld_bnd) begin
            r_cre  <= r_in_re;
            r_cim  <= r_in_im;
            r_cpot <= r_in_pot;
            r_kre  <= '0;
            r_kim  <= '0;
        end
        if (i_cmd.uop.mul != MUL_NONE) begin
            r_prod <= w_prod;
        end
        case (i_cmd.uop.acc)
            ACC_DENS_LO: r_t    <= w_qx;
            ACC_DENS_HI: r_dens <= f_sat32(r_t + w_qx);
            ACC_S:       r_s    <= f_sat32(ACC_W'(r_cpot) + w_qx);
            ACC_KRE_ADD: r_kre  <= r_kre + w_qx;
            ACC_KIM_ADD: r_kim  <= r_kim + w_qx;
            ACC_KRE_SUB: r_kre  <= r_kre - w_qx;
            ACC_KIM_SUB: r_kim  <= r_kim - w_qx;
            default:     r_t    <= r_t;
        endcase
        if (i_cmd.load_out) begin
            o_k_re    <= f_sat32(r_kre);
            o_k_im    <= f_sat32(r_kim);
            o_out_row <= i_cmd.out_row;
            o_out_col <= i_cmd.out_col;
            o_last    <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sts.out_free = ~r_out_valid | ~i_out_stall;

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_out_valid)
        else $error("loaded result not presented");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> !i_cmd.rd_en && !i_cmd.prd_en)
        else $error("line store written during a read sweep");

    a_mul_idle_when_loading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ld_int || i_cmd.ld_bnd) |-> i_cmd.uop.mul == MUL_NONE)
        else $error("multiplier issued while operands are reloaded");

endmodule
`default_nettype wire
